[hw/rtl/eps_pkg.sv]
// Package for the EIT section PDC scanner: widths, register indexes,
// configuration and result types. No dependencies.
package eps_pkg;

    localparam int MAX_SECTION_BYTES_DEF = 4096;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 20;
    localparam int OUT_DATA_W = 56;

    localparam logic [CFG_IDX_W-1:0] REG_WANTED_SERVICE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WANTED_NETWORK = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WANTED_STREAM  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WANTED_LABEL   = 8'd3;

    localparam logic [7:0]  PDC_TAG        = 8'd105;
    localparam logic [11:0] BODY_MIN_LEN   = 12'd27;
    localparam logic [8:0]  PDC_MIN_SIZE   = 9'd5;

    typedef struct packed {
        logic [15:0] service;
        logic [15:0] network;
        logic [15:0] stream;
        logic [19:0] label;
    } t_cfg;

    // header_ok sits in bit 0, fields follow upward
    typedef struct packed {
        logic        truncated;
        logic        pdc_match;
        logic [19:0] pdc_label;
        logic        pdc_present;
        logic [2:0]  run_state;
        logic [15:0] event_number;
        logic [7:0]  section_index;
        logic        header_only;
        logic        header_ok;
    } t_result;

endpackage

[hw/rtl/eps_byte_parser.sv]
// Per-byte section parser: header checks, first event fields and PDC
// descriptor walk. Depends on eps_pkg.
module eps_byte_parser #(
    parameter int MAX_SECTION_BYTES = eps_pkg::MAX_SECTION_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    input  eps_pkg::t_cfg    i_cfg,
    output logic             o_res_valid,
    output eps_pkg::t_result o_res
);

    localparam int POS_W = $clog2(MAX_SECTION_BYTES + 1);

    logic [POS_W-1:0] r_pos,        n_pos;
    logic [11:0]      r_len,        n_len;
    logic [3:0]       r_id_ok,      n_id_ok;
    logic [7:0]       r_id_shift,   n_id_shift;
    logic [7:0]       r_section,    n_section;
    logic [15:0]      r_event,      n_event;
    logic [2:0]       r_status,     n_status;
    logic [11:0]      r_loop_rem,   n_loop_rem;
    logic [8:0]       r_desc_off,   n_desc_off;
    logic [8:0]       r_desc_size,  n_desc_size;
    logic             r_desc_pdc,   n_desc_pdc;
    logic [19:0]      r_label_acc,  n_label_acc;
    logic [19:0]      r_kept_label, n_kept_label;
    logic [1:0]       r_pdc_flags,  n_pdc_flags;
    logic             r_loop_open,  n_loop_open;

    logic             w_only;
    logic             w_ok;
    logic             w_trunc;

    always_comb begin
        logic [POS_W-1:0] p;
        logic             skip;
        p            = r_pos;
        skip         = 1'b0;
        n_pos        = r_pos;
        n_len        = r_len;
        n_id_ok      = r_id_ok;
        n_id_shift   = r_id_shift;
        n_section    = r_section;
        n_event      = r_event;
        n_status     = r_status;
        n_loop_rem   = r_loop_rem;
        n_desc_off   = r_desc_off;
        n_desc_size  = r_desc_size;
        n_desc_pdc   = r_desc_pdc;
        n_label_acc  = r_label_acc;
        n_kept_label = r_kept_label;
        n_pdc_flags  = r_pdc_flags;
        n_loop_open  = r_loop_open;

        if (p < POS_W'(MAX_SECTION_BYTES)) begin
            if (p == POS_W'(1)) begin
                n_len = {i_byte[3:0], 8'd0};
            end else if (p == POS_W'(2)) begin
                n_len = {r_len[11:8], i_byte};
            end else if (p == POS_W'(4)) begin
                if ({r_id_shift, i_byte} != i_cfg.service) n_id_ok[0] = 1'b0;
            end else if (p == POS_W'(5)) begin
                if (!i_byte[0]) n_id_ok[3] = 1'b0;
            end else if (p == POS_W'(6)) begin
                n_section = i_byte;
            end else if (p == POS_W'(9)) begin
                if ({r_id_shift, i_byte} != i_cfg.stream) n_id_ok[1] = 1'b0;
            end else if (p == POS_W'(11)) begin
                if ({r_id_shift, i_byte} != i_cfg.network) n_id_ok[2] = 1'b0;
            end

            if (p >= POS_W'(14) && n_len > eps_pkg::BODY_MIN_LEN) begin
                if (p == POS_W'(14)) begin
                    n_event = {i_byte, 8'd0};
                end else if (p == POS_W'(15)) begin
                    n_event = {r_event[15:8], i_byte};
                end else if (p == POS_W'(24)) begin
                    n_status   = i_byte[7:5];
                    n_loop_rem = {i_byte[3:0], 8'd0};
                end else if (p == POS_W'(25)) begin
                    n_loop_rem  = {r_loop_rem[11:8], i_byte};
                    n_loop_open = (n_loop_rem != 12'd0);
                end else if (p >= POS_W'(26) && r_loop_open) begin
                    // descriptor loop walk
                    if (r_desc_off == 9'd0) begin
                        if (r_loop_rem == 12'd0) begin
                            n_loop_open = 1'b0;
                            skip        = 1'b1;
                        end else begin
                            n_desc_pdc = (i_byte == eps_pkg::PDC_TAG);
                            if (n_desc_pdc) n_pdc_flags[0] = 1'b1;
                            n_desc_off = 9'd1;
                        end
                    end else if (r_desc_off == 9'd1) begin
                        n_desc_size = {1'b0, i_byte} + 9'd2;
                        n_desc_off  = 9'd2;
                    end else begin
                        if (r_desc_pdc && r_desc_size >= eps_pkg::PDC_MIN_SIZE) begin
                            if (r_desc_off == 9'd2) begin
                                n_label_acc = {i_byte[3:0], 16'd0};
                            end else if (r_desc_off == 9'd3) begin
                                n_label_acc = {r_label_acc[19:16], i_byte, 8'd0};
                            end else if (r_desc_off == 9'd4) begin
                                n_label_acc  = {r_label_acc[19:8], i_byte};
                                n_kept_label = n_label_acc;
                                if (n_label_acc == i_cfg.label) n_pdc_flags[1] = 1'b1;
                            end
                        end
                        n_desc_off = r_desc_off + 9'd1;
                    end
                    if (!skip) begin
                        if (r_loop_rem != 12'd0) n_loop_rem = r_loop_rem - 12'd1;
                        if (n_desc_off >= 9'd2 && n_desc_off >= n_desc_size) begin
                            n_desc_off = 9'd0;
                        end
                        if (n_desc_off == 9'd0 && n_loop_rem == 12'd0) n_loop_open = 1'b0;
                    end
                end
            end
            n_id_shift = i_byte;
            n_pos      = p + POS_W'(1);
        end
    end

    assign w_ok    = (n_id_ok == 4'hF) && (n_pos >= POS_W'(12));
    assign w_only  = (n_len <= eps_pkg::BODY_MIN_LEN);
    assign w_trunc = !w_only && ((n_pos < POS_W'(26)) || n_loop_open);

    assign o_res_valid = i_take && i_last;

    always_comb begin
        o_res = '0;
        if (w_ok) begin
            o_res.header_ok     = 1'b1;
            o_res.header_only   = w_only;
            o_res.section_index = n_section;
            if (!w_only) begin
                o_res.event_number = n_event;
                o_res.run_state    = n_status;
                o_res.pdc_present  = n_pdc_flags[0];
                o_res.pdc_label    = n_kept_label;
                o_res.pdc_match    = n_pdc_flags[1];
                o_res.truncated    = w_trunc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_last)) begin
            r_pos        <= '0;
            r_len        <= '0;
            r_id_ok      <= 4'hF;
            r_id_shift   <= '0;
            r_section    <= '0;
            r_event      <= '0;
            r_status     <= '0;
            r_loop_rem   <= '0;
            r_desc_off   <= '0;
            r_desc_size  <= '0;
            r_desc_pdc   <= 1'b0;
            r_label_acc  <= '0;
            r_kept_label <= '0;
            r_pdc_flags  <= '0;
            r_loop_open  <= 1'b0;
        end else if (i_take) begin
            r_pos        <= n_pos;
            r_len        <= n_len;
            r_id_ok      <= n_id_ok;
            r_id_shift   <= n_id_shift;
            r_section    <= n_section;
            r_event      <= n_event;
            r_status     <= n_status;
            r_loop_rem   <= n_loop_rem;
            r_desc_off   <= n_desc_off;
            r_desc_size  <= n_desc_size;
            r_desc_pdc   <= n_desc_pdc;
            r_label_acc  <= n_label_acc;
            r_kept_label <= n_kept_label;
            r_pdc_flags  <= n_pdc_flags;
            r_loop_open  <= n_loop_open;
        end
    end

endmodule

[hw/rtl/eit_section_pdc_scanner.sv]
// Top level of the EIT section PDC scanner: config registers, parser and
// result register. Depends on eps_pkg and eps_byte_parser.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata: data_byte; tlast: end_of_section
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata: result fields, header_ok lowest
//  cfg       in   i_cfg_wr_en                    i_cfg_index, i_cfg_wdata
//
// One byte per cycle unless stalled; bytes pass through the parser's combinational update.
// A result appears in the output register the cycle after its last byte.
// Input stalls only while a result waits in the output register and is not taken.
// Synchronous active-low reset clears config to zero and restarts section state.
module eit_section_pdc_scanner #(
    parameter int MAX_SECTION_BYTES = eps_pkg::MAX_SECTION_BYTES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,  // [7:0] data_byte
    input  logic                             s_axis_tlast,  // end_of_section
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [0] header_ok, [1] header_only, [9:2] section_index, [25:10] event_number,
    // [28:26] run_state, [29] pdc_present, [49:30] pdc_label, [50] pdc_match,
    // [51] truncated, [55:52] zero
    output logic [eps_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic                             i_cfg_wr_en,
    input  logic [eps_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [eps_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);

    eps_pkg::t_cfg    r_cfg;
    eps_pkg::t_result r_out;
    eps_pkg::t_result w_res;
    logic             r_out_valid;
    logic             w_take;
    logic             w_res_valid;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_take        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                eps_pkg::REG_WANTED_SERVICE: r_cfg.service <= i_cfg_wdata[15:0];
                eps_pkg::REG_WANTED_NETWORK: r_cfg.network <= i_cfg_wdata[15:0];
                eps_pkg::REG_WANTED_STREAM:  r_cfg.stream  <= i_cfg_wdata[15:0];
                eps_pkg::REG_WANTED_LABEL:   r_cfg.label   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    eps_byte_parser #(
        .MAX_SECTION_BYTES(MAX_SECTION_BYTES)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (w_take),
        .i_byte      (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .i_cfg       (r_cfg),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out};

    a_stall_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no pending result");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> m_axis_tvalid)
        else $error("last byte produced no result");

    a_rejected_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !r_out.header_ok) |-> (r_out == '0))
        else $error("rejected header carries nonzero fields");

    a_header_only_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_out.header_only) |->
        (r_out.event_number == 16'd0 && !r_out.pdc_present && !r_out.truncated
         && !r_out.pdc_match && r_out.pdc_label == 20'd0))
        else $error("header-only section carries event fields");

endmodule

[tb/eps_result_checker.sv]
`timescale 1ns / 100ps
// Result checker for eit_section_pdc_scanner: rebuilds each section's outcome
// from the accepted bytes and register writes, and compares every accepted
// result with it. Depends on eps_pkg.
module eps_result_checker #(
    parameter int MAX_SECTION_BYTES = eps_pkg::MAX_SECTION_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_byte_valid,
    input  logic                           i_byte_ready,
    input  logic [7:0]                     i_byte,
    input  logic                           i_byte_last,
    input  logic                           i_res_valid,
    input  logic                           i_res_ready,
    input  logic [eps_pkg::OUT_DATA_W-1:0] i_res_data,
    input  logic                           i_cfg_wr_en,
    input  logic [eps_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [eps_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_checked
);
    import eps_pkg::*;

    t_cfg        cfg;
    t_result     pending_results[$];
    int          n_fail;
    int          n_checked;

    // per-section parser state
    logic [12:0] byte_pos;
    logic [11:0] sec_len;
    logic [3:0]  id_ok;
    logic [7:0]  prev_byte;
    logic [7:0]  sec_num;
    logic [15:0] evt_id;
    logic [2:0]  run_st;
    logic [12:0] loop_left;
    logic [8:0]  d_off;
    logic [8:0]  d_size;
    logic        d_is_pdc;
    logic [19:0] lbl_acc;
    logic [19:0] lbl_kept;
    logic        seen_pdc;
    logic        seen_match;
    logic        loop_open;

    function automatic void clear_section();
        byte_pos = '0; sec_len = '0; id_ok = 4'hF; prev_byte = '0;
        sec_num = '0; evt_id = '0; run_st = '0; loop_left = '0;
        d_off = '0; d_size = '0; d_is_pdc = 1'b0; lbl_acc = '0; lbl_kept = '0;
        seen_pdc = 1'b0; seen_match = 1'b0; loop_open = 1'b0;
    endfunction

    function automatic void walk_descriptors(input logic [7:0] b);
        if (d_off == 9'd0) begin
            if (loop_left == 13'd0) begin
                loop_open = 1'b0;
                return;
            end
            d_is_pdc = (b == PDC_TAG);
            if (d_is_pdc) seen_pdc = 1'b1;
            d_off = 9'd1;
        end else if (d_off == 9'd1) begin
            d_size = {1'b0, b} + 9'd2;
            d_off = 9'd2;
        end else begin
            if (d_is_pdc && d_size >= PDC_MIN_SIZE) begin
                if (d_off == 9'd2) begin
                    lbl_acc = {b[3:0], 16'h0000};
                end else if (d_off == 9'd3) begin
                    lbl_acc = lbl_acc | {4'h0, b, 8'h00};
                end else if (d_off == 9'd4) begin
                    lbl_acc = lbl_acc | {12'h000, b};
                    lbl_kept = lbl_acc;
                    if (lbl_kept == cfg.label) seen_match = 1'b1;
                end
            end
            d_off = d_off + 9'd1;
        end
        if (loop_left != 13'd0) loop_left = loop_left - 13'd1;
        if (d_off >= 9'd2 && d_off >= d_size) d_off = 9'd0;
        if (d_off == 9'd0 && loop_left == 13'd0) loop_open = 1'b0;
    endfunction

    function automatic void parse_byte(input logic [7:0] b);
        case (byte_pos)
            13'd1:  sec_len = {b[3:0], 8'h00};
            13'd2:  sec_len = sec_len | {4'h0, b};
            13'd4:  if ({prev_byte, b} != cfg.service) id_ok[0] = 1'b0;
            13'd5:  if (!b[0]) id_ok[3] = 1'b0;
            13'd6:  sec_num = b;
            13'd9:  if ({prev_byte, b} != cfg.stream) id_ok[1] = 1'b0;
            13'd11: if ({prev_byte, b} != cfg.network) id_ok[2] = 1'b0;
            default: ;
        endcase
        if (byte_pos >= 13'd14 && sec_len > BODY_MIN_LEN) begin
            if (byte_pos == 13'd14) begin
                evt_id = {b, 8'h00};
            end else if (byte_pos == 13'd15) begin
                evt_id = evt_id | {8'h00, b};
            end else if (byte_pos == 13'd24) begin
                run_st = b[7:5];
                loop_left = {1'b0, b[3:0], 8'h00};
            end else if (byte_pos == 13'd25) begin
                loop_left = loop_left | {5'h00, b};
                loop_open = (loop_left != 13'd0);
            end else if (byte_pos >= 13'd26 && loop_open) begin
                walk_descriptors(b);
            end
        end
        prev_byte = b;
        byte_pos = byte_pos + 13'd1;
    endfunction

    function automatic void close_section();
        logic    hdr_ok;
        logic    hdr_only;
        logic    cut;
        t_result r;
        hdr_ok = (id_ok == 4'hF) && (byte_pos >= 13'd12);
        hdr_only = (sec_len <= BODY_MIN_LEN);
        cut = !hdr_only && ((byte_pos < 13'd26) || loop_open);
        r = '0;
        if (hdr_ok) begin
            r.header_ok = 1'b1;
            r.header_only = hdr_only;
            r.section_index = sec_num;
            if (!hdr_only) begin
                r.event_number = evt_id;
                r.run_state = run_st;
                r.pdc_present = seen_pdc;
                r.pdc_label = lbl_kept;
                r.pdc_match = seen_match;
                r.truncated = cut;
            end
        end
        pending_results.push_back(r);
        clear_section();
    endfunction

    function automatic void check_field(input string name, input logic [19:0] want,
                                        input logic [19:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            n_fail++;
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            cfg = '0;
            clear_section();
            pending_results.delete();
            n_fail = 0;
            n_checked = 0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_WANTED_SERVICE: cfg.service = i_cfg_wdata[15:0];
                    REG_WANTED_NETWORK: cfg.network = i_cfg_wdata[15:0];
                    REG_WANTED_STREAM:  cfg.stream = i_cfg_wdata[15:0];
                    REG_WANTED_LABEL:   cfg.label = i_cfg_wdata;
                    default: ;
                endcase
            end
            // results first, so a stray result never pairs with this edge's section
            if (i_res_valid && i_res_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result 0x%h with no section outstanding", i_res_data);
                    n_fail++;
                end else begin
                    want = pending_results.pop_front();
                    got = t_result'(i_res_data[$bits(t_result)-1:0]);
                    check_field("header_ok", 20'(want.header_ok), 20'(got.header_ok));
                    check_field("header_only", 20'(want.header_only), 20'(got.header_only));
                    check_field("section_index", 20'(want.section_index),
                                20'(got.section_index));
                    check_field("event_number", 20'(want.event_number),
                                20'(got.event_number));
                    check_field("run_state", 20'(want.run_state), 20'(got.run_state));
                    check_field("pdc_present", 20'(want.pdc_present), 20'(got.pdc_present));
                    check_field("pdc_label", want.pdc_label, got.pdc_label);
                    check_field("pdc_match", 20'(want.pdc_match), 20'(got.pdc_match));
                    check_field("truncated", 20'(want.truncated), 20'(got.truncated));
                    n_checked++;
                end
            end
            if (i_byte_valid && i_byte_ready) begin
                // bytes past the size limit only count for their end flag
                if (int'(byte_pos) < MAX_SECTION_BYTES) parse_byte(i_byte);
                if (i_byte_last) close_section();
            end
        end
        o_fail_count <= n_fail;
        o_pending <= pending_results.size();
        o_checked <= n_checked;
    end

endmodule

[tb/tb_eit_section_pdc_scanner.sv]
`timescale 1ns / 100ps
// Top of the eit_section_pdc_scanner testbench: clock, reset, section and
// register stimulus, watchdog and verdict. Depends on eps_pkg, the scanner
// and eps_result_checker.
module tb_eit_section_pdc_scanner;
    import eps_pkg::*;

    localparam int RANDOM_BYTES   = 800;
    localparam int RANDOM_RESULTS = 16;
    localparam int WATCHDOG_LIMIT = 1000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata;
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    int         fail_count;
    int         pending;
    int         checked;
    int         quiet_cycles = 0;
    int         n_bytes = 0;
    int         n_sections = 0;
    int         n_settings = 0;
    logic       calm = 1'b0;
    t_cfg       cur_cfg = '0;
    logic [7:0] sec_q[$];
    logic [7:0] loop_q[$];

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    eit_section_pdc_scanner dut (
        .i_clk,
        .i_rst_n,
        .s_axis_tvalid,
        .s_axis_tready,
        .s_axis_tdata,
        .s_axis_tlast,
        .m_axis_tvalid,
        .m_axis_tready,
        .m_axis_tdata,
        .i_cfg_wr_en,
        .i_cfg_index,
        .i_cfg_wdata
    );

    eps_result_checker u_checker (
        .i_clk,
        .i_rst_n,
        .i_byte_valid (s_axis_tvalid),
        .i_byte_ready (s_axis_tready),
        .i_byte       (s_axis_tdata),
        .i_byte_last  (s_axis_tlast),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .i_cfg_wr_en,
        .i_cfg_index,
        .i_cfg_wdata,
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always @(posedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(99) >= 16);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL eit_section_pdc_scanner");
            $finish;
        end
    end

    function automatic logic [7:0] rnd8();
        return 8'($urandom);
    endfunction

    function automatic void set12(input int at, input logic [11:0] value);
        sec_q[at] = {sec_q[at][7:4], value[11:8]};
        sec_q[at + 1] = value[7:0];
    endfunction

    function automatic void trim_section(input int keep);
        while (sec_q.size() > keep) void'(sec_q.pop_back());
    endfunction

    function automatic void add_desc(input logic [7:0] tag, input logic [7:0] len);
        loop_q.push_back(tag);
        loop_q.push_back(len);
        repeat (len) loop_q.push_back(rnd8());
    endfunction

    function automatic void add_pdc(input logic [19:0] label, input logic [7:0] len);
        loop_q.push_back(PDC_TAG);
        loop_q.push_back(len);
        for (int k = 0; k < int'(len); k++) begin
            case (k)
                0:       loop_q.push_back({rnd8() & 8'hF0} | {4'h0, label[19:16]});
                1:       loop_q.push_back(label[15:8]);
                2:       loop_q.push_back(label[7:0]);
                default: loop_q.push_back(rnd8());
            endcase
        end
    endfunction

    // header for the current ids, loop_q as the first event's loop, trailing
    // bytes and CRC; both length fields agree with the bytes (section length capped at 4095)
    function automatic void build_section(input int n_trail);
        logic [7:0] b;
        sec_q.delete();
        sec_q.push_back(rnd8());
        sec_q.push_back(rnd8());
        sec_q.push_back(8'h00);
        sec_q.push_back(cur_cfg.service[15:8]);
        sec_q.push_back(cur_cfg.service[7:0]);
        b = rnd8();
        b[0] = 1'b1;
        sec_q.push_back(b);
        sec_q.push_back(rnd8());
        sec_q.push_back(rnd8());
        sec_q.push_back(cur_cfg.stream[15:8]);
        sec_q.push_back(cur_cfg.stream[7:0]);
        sec_q.push_back(cur_cfg.network[15:8]);
        sec_q.push_back(cur_cfg.network[7:0]);
        repeat (12) sec_q.push_back(rnd8());
        sec_q.push_back(rnd8());
        sec_q.push_back(8'h00);
        foreach (loop_q[k]) sec_q.push_back(loop_q[k]);
        repeat (n_trail) sec_q.push_back(rnd8());
        set12(24, 12'(loop_q.size()));
        set12(1, (sec_q.size() + 1 > 4095) ? 12'hFFF : 12'(sec_q.size() + 1));
        repeat (4) sec_q.push_back(rnd8());
    endfunction

    task automatic put_byte(input logic [7:0] b, input logic last);
        while (!calm && $urandom_range(99) < 16) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        n_bytes++;
    endtask

    task automatic send_section();
        foreach (sec_q[k]) put_byte(sec_q[k], k == sec_q.size() - 1);
        n_sections++;
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [19:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        case (idx)
            REG_WANTED_SERVICE: cur_cfg.service = value[15:0];
            REG_WANTED_NETWORK: cur_cfg.network = value[15:0];
            REG_WANTED_STREAM:  cur_cfg.stream = value[15:0];
            REG_WANTED_LABEL:   cur_cfg.label = value;
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [19:0] service, input logic [19:0] network,
                                input logic [19:0] stream, input logic [19:0] label);
        write_reg(REG_WANTED_SERVICE, service);
        write_reg(REG_WANTED_NETWORK, network);
        write_reg(REG_WANTED_STREAM, stream);
        write_reg(REG_WANTED_LABEL, label);
        // unused index, must leave all registers alone
        write_reg(8'($urandom_range(4, 255)), 20'($urandom));
        i_cfg_wr_en <= 1'b0;
        n_settings++;
    endtask

    task automatic run_directed();
        int keep_at[6] = '{1, 5, 11, 12, 20, 35};
        // one plain descriptor, then a matching label
        loop_q.delete();
        add_desc(8'h4D, 8'd5);
        add_pdc(cur_cfg.label, 8'd3);
        build_section(0);
        send_section();
        // early match, last label kept, a further label after the loop ignored
        loop_q.delete();
        add_pdc(cur_cfg.label, 8'd3);
        add_desc(8'h54, 8'd2);
        add_pdc(~cur_cfg.label, 8'd3);
        add_pdc(cur_cfg.label ^ 20'h00001, 8'd3);
        build_section(6);
        set12(24, 12'(loop_q.size() - 5));
        send_section();
        // length field at the header-only boundary, then one above with no loop
        loop_q.delete();
        add_pdc(cur_cfg.label, 8'd3);
        build_section(0);
        set12(1, BODY_MIN_LEN);
        send_section();
        loop_q.delete();
        build_section(0);
        set12(1, BODY_MIN_LEN + 12'd1);
        send_section();
        // each id wrong in turn, and current_next clear
        for (int k = 0; k < 4; k++) begin
            loop_q.delete();
            add_pdc(cur_cfg.label, 8'd3);
            build_section(0);
            case (k)
                0:       sec_q[4] = sec_q[4] ^ 8'h01;
                1:       sec_q[5] = sec_q[5] & 8'hFE;
                2:       sec_q[8] = sec_q[8] ^ 8'h80;
                default: sec_q[10] = sec_q[10] ^ 8'h80;
            endcase
            send_section();
        end
        // ended early: inside the header, before the loop length, inside a label
        foreach (keep_at[k]) begin
            loop_q.delete();
            add_desc(8'h4D, 8'd4);
            add_pdc(cur_cfg.label, 8'd3);
            build_section(0);
            trim_section(keep_at[k]);
            send_section();
        end
        // descriptor starting inside the loop and running past its end
        loop_q.delete();
        add_desc(8'h4D, 8'd2);
        add_pdc(cur_cfg.label, 8'd3);
        build_section(4);
        set12(24, 12'd5);
        send_section();
        // PDC descriptors too short for a label, then one longer than usual
        loop_q.delete();
        add_pdc(cur_cfg.label, 8'd0);
        add_pdc(cur_cfg.label, 8'd1);
        add_pdc(cur_cfg.label, 8'd2);
        build_section(0);
        send_section();
        loop_q.delete();
        add_pdc(cur_cfg.label, 8'd6);
        build_section(0);
        send_section();
        // all-zero and all-one bytes
        sec_q.delete();
        repeat (40) sec_q.push_back(8'h00);
        send_section();
        sec_q.delete();
        repeat (40) sec_q.push_back(8'hFF);
        send_section();
    endtask

    task automatic rand_section();
        int         id_pos[7] = '{3, 4, 5, 8, 9, 10, 11};
        int         pos;
        int         len;
        logic [19:0] label;
        if ($urandom_range(99) < 8) begin
            sec_q.delete();
            repeat ($urandom_range(1, 40)) sec_q.push_back(rnd8());
        end else begin
            loop_q.delete();
            repeat ($urandom_range(0, 4)) begin
                if ($urandom_range(99) < 45) begin
                    label = $urandom_range(1) ? cur_cfg.label : 20'($urandom);
                    len = ($urandom_range(99) < 85) ? 3 : $urandom_range(0, 6);
                    add_pdc(label, 8'(len));
                end else begin
                    len = ($urandom_range(99) < 95) ? $urandom_range(0, 10)
                                                    : $urandom_range(0, 255);
                    add_desc(rnd8(), 8'(len));
                end
            end
            build_section($urandom_range(0, 12));
            if ($urandom_range(99) < 12) begin
                pos = id_pos[$urandom_range(6)];
                sec_q[pos] = sec_q[pos] ^ ((pos == 5) ? 8'h01 : 8'(1 << $urandom_range(7)));
            end
            if ($urandom_range(99) < 10) set12(24, 12'($urandom_range(0, loop_q.size() + 8)));
            if ($urandom_range(99) < 8) set12(1, 12'($urandom_range(0, 60)));
            if ($urandom_range(99) < 10) trim_section($urandom_range(1, sec_q.size()));
        end
        send_section();
    endtask

    initial begin
        int directed_bytes;
        int directed_sections;
        int phase;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = '0;
        i_cfg_wdata = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        program_regs(20'h31234, 20'h00085, 20'h05A5A, 20'h8A5C3);
        run_directed();
        settle();
        directed_bytes = n_bytes;
        directed_sections = n_sections;

        phase = 0;
        while (n_bytes - directed_bytes < RANDOM_BYTES ||
               n_sections - directed_sections < RANDOM_RESULTS) begin
            case (phase % 4)
                0:       program_regs(20'h00000, 20'h00000, 20'h00000, 20'h00000);
                1:       program_regs(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
                default: program_regs(20'($urandom), 20'($urandom), 20'($urandom),
                                      20'($urandom));
            endcase
            calm = (phase == 2);
            repeat (4) rand_section();
            settle();
            phase++;
        end
        calm = 1'b0;
        repeat (8) @(posedge i_clk);

        $display("Sent %0d sections (%0d bytes) under %0d register settings",
                 n_sections, n_bytes, n_settings);
        $display("Checked %0d results, %0d mismatches", checked, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS eit_section_pdc_scanner");
        end else begin
            $display("FAIL eit_section_pdc_scanner");
        end
        $finish;
    end

endmodule

[eit_section_pdc_scanner.f]
hw/rtl/eps_pkg.sv
hw/rtl/eps_byte_parser.sv
hw/rtl/eit_section_pdc_scanner.sv
tb/eps_result_checker.sv
tb/tb_eit_section_pdc_scanner.sv
